FILE: design/atr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_pkg: shared types and constants of the allocation tracker
// Item layouts, table entry layout, status and sequencer codes.
// ----------------------------------------------------------------------------
package atr_pkg;

    localparam int ADDR_W            = 32;
    localparam int SIZE_W            = 17;
    localparam int CUR_W             = 23;
    localparam int TOT_W             = 48;
    localparam int AGE_W             = 48;
    localparam int TABLE_DEPTH_DEF   = 64;

    localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Event codes of the func field
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NULL_ALLOC   = 3'd1,
        ST_NULL_FREE    = 3'd2,
        ST_UNKNOWN_FREE = 3'd3,
        ST_FULL         = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SIZE_W-1:0] freed_size;
        logic [CUR_W-1:0]  current_bytes;
        logic [CUR_W-1:0]  peak_bytes;
        logic [TOT_W-1:0]  total_bytes;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic [AGE_W-1:0]  age;
    } entry_t;

endpackage

FILE: design/atr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module atr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/allocation_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_tracker_top: bounded table of live heap allocations
// Inserts allocations, removes the newest matching entry on a free, and
// keeps saturating current, peak and cumulative byte totals.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  request  | req_valid / req_stall | req: func, address, size
//  response | rsp_valid / rsp_stall | rsp: status, freed_size, current_bytes,
//           |                       |      peak_bytes, total_bytes
//
//  An item with a nonzero address is scanned against the whole table: one
//  table entry is read and compared per cycle through the single read port
//  of the entry RAM, then the commit state writes the entry if a slot or a
//  match was found. A null-address item goes straight to the commit state.
//  The next item is taken in the cycle after its response has left the
//  output register. After reset the block sweeps the entry RAM to clear all
//  valid marks; req_stall stays high during that pass.
//  A stalled response holds in the output register.
//
module allocation_tracker_top
    import atr_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);

    // Control registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [CUR_W-1:0]  peak_reg, peak_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;

    // Payload registers
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  hit_reg, hit_next;
    logic [AGE_W-1:0]  best_age_reg, best_age_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    rsp_t              rsp_reg, rsp_next;

    // Entry RAM signals
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wentry;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                 rd_entry;

    // Shared compare unit and totals arithmetic
    logic              addr_match;
    logic              age_newer;
    logic              take;
    logic [CUR_W:0]    cur_sum;
    logic [CUR_W-1:0]  cur_add;
    logic [TOT_W:0]    tot_sum;

    atr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry   = entry_t'(ram_rdata);
    assign addr_match = rd_entry.valid && (rd_entry.address == req_reg.address);
    assign age_newer  = rd_entry.age > best_age_reg;

    // Pick the lowest free slot on alloc, the newest matching entry on free
    always_comb
    begin
        if (req_reg.func == FUNC_ALLOC)
        begin
            take = rd_pend_reg && !found_reg && !rd_entry.valid;
        end
        else
        begin
            take = rd_pend_reg && addr_match && (!found_reg || age_newer);
        end
    end

    // Saturating totals for an allocation
    assign cur_sum = {1'b0, cur_reg} + (CUR_W+1)'(req_reg.size);
    assign cur_add = cur_sum[CUR_W] ? CUR_MAX : cur_sum[CUR_W-1:0];
    assign tot_sum = {1'b0, tot_reg} + (TOT_W+1)'(req_reg.size);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            age_reg       <= '0;
            cur_reg       <= '0;
            peak_reg      <= '0;
            tot_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            age_reg       <= age_next;
            cur_reg       <= cur_next;
            peak_reg      <= peak_next;
            tot_reg       <= tot_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hit_reg       <= hit_next;
        best_age_reg  <= best_age_next;
        best_size_reg <= best_size_next;
        rsp_reg       <= rsp_next;
    end

    // Sequencer: clear pass, accept, scan, commit
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = cnt_reg[IDX_W-1:0];
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        age_next       = age_reg;
        cur_next       = cur_reg;
        peak_next      = peak_reg;
        tot_next       = tot_reg;
        req_next       = req_reg;
        hit_next       = hit_reg;
        best_age_next  = best_age_reg;
        best_size_next = best_size_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wentry     = '0;
        req_stall      = 1'b1;

        // Drop the response once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                req_stall = rsp_valid_reg;
                if (req_valid && !rsp_valid_reg)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    if (age_reg != AGE_MAX)
                    begin
                        age_next = age_reg + 1'b1;
                    end
                    if (req.address == '0)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle, judge the entry read last cycle
                if (cnt_reg != CNT_END)
                begin
                    rd_pend_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    hit_next       = rd_idx_reg;
                    best_age_next  = rd_entry.age;
                    best_size_next = rd_entry.size;
                end
            end

            S_COMMIT:
            begin
                rsp_next.freed_size = '0;
                ram_waddr           = hit_reg;
                if (req_reg.address == '0)
                begin
                    rsp_next.status = (req_reg.func == FUNC_ALLOC) ? ST_NULL_ALLOC
                                                                   : ST_NULL_FREE;
                end
                else if (req_reg.func == FUNC_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        rsp_next.status    = ST_OK;
                        ram_we             = 1'b1;
                        ram_wentry.valid   = 1'b1;
                        ram_wentry.address = req_reg.address;
                        ram_wentry.size    = req_reg.size;
                        ram_wentry.age     = age_reg;
                        cur_next           = cur_add;
                        if (cur_add > peak_reg)
                        begin
                            peak_next = cur_add;
                        end
                        tot_next = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        rsp_next.status = ST_UNKNOWN_FREE;
                    end
                    else
                    begin
                        rsp_next.status     = ST_OK;
                        rsp_next.freed_size = best_size_reg;
                        ram_we              = 1'b1;
                        if (cur_reg >= CUR_W'(best_size_reg))
                        begin
                            cur_next = cur_reg - CUR_W'(best_size_reg);
                        end
                        else
                        begin
                            cur_next = '0;
                        end
                    end
                end
                rsp_next.current_bytes = cur_next;
                rsp_next.peak_bytes    = peak_next;
                rsp_next.total_bytes   = tot_next;
                rsp_valid_next         = 1'b1;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: design/atr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_checker: port-level checks of the allocation tracker
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module atr_checker
    import atr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // A stalled response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled request stays offered and unchanged
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an item is in flight");

    // Only a successful free reports released bytes
    a_freed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.freed_size == '0))
        else $error("freed size reported on a failed event");

    // Peak never falls below current usage
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.peak_bytes >= rsp.current_bytes))
        else $error("peak below current usage");

endmodule

bind allocation_tracker_top atr_checker u_atr_checker (.*);

FILE: tb/allocation_tracker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_tracker_top_tb: self-checking bench for the allocation tracker
// Runs a short table of directed items, then random episodes that fill the
// table, churn a small set of addresses, drain it, and throw noise at it. Each
// response is compared field by field against its typed row or an in-bench model.
// ----------------------------------------------------------------------------
module allocation_tracker_top_tb;
    import atr_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 3 * (DEPTH + 2);
    localparam int POOL_N       = 8;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    allocation_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Model of the live-block table and usage totals
    logic              live_valid [DEPTH];
    logic [ADDR_W-1:0] live_addr  [DEPTH];
    logic [SIZE_W-1:0] live_size  [DEPTH];
    logic [AGE_W-1:0]  live_age   [DEPTH];
    logic [AGE_W-1:0]  event_age;
    logic [CUR_W-1:0]  usage_now;
    logic [CUR_W-1:0]  usage_peak;
    logic [TOT_W-1:0]  usage_total;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } script_row_t;

    script_row_t       script [$];
    rsp_t              pending_rsp [$];
    logic [ADDR_W-1:0] addr_pool [POOL_N];
    int                status_seen [5];
    int                sender_idle_pct   = 0;
    int                receiver_idle_pct = 0;
    int                idle_mix          = 0;
    int                random_sent       = 0;
    int                items_sent        = 0;
    int                rsp_seen          = 0;
    int                error_count       = 0;
    int                quiet_cycles      = 0;

    // Apply one event to the table model and return the response it yields
    function automatic rsp_t track_event(req_t ev);
        rsp_t           res;
        int             slot;
        int             hit;
        logic [CUR_W:0] cur_sum;
        logic [TOT_W:0] tot_sum;
        res  = '0;
        slot = -1;
        hit  = -1;
        if (event_age != AGE_MAX)
            event_age = event_age + 1'b1;
        res.status = ST_OK;
        if (ev.func == FUNC_ALLOC) begin
            if (ev.address == '0)
                res.status = ST_NULL_ALLOC;
            else begin
                // lowest free slot
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !live_valid[i])
                        slot = i;
                if (slot < 0)
                    res.status = ST_FULL;
                else begin
                    live_valid[slot] = 1'b1;
                    live_addr[slot]  = ev.address;
                    live_size[slot]  = ev.size;
                    live_age[slot]   = event_age;
                    cur_sum   = {1'b0, usage_now} + ev.size;
                    usage_now = (cur_sum > CUR_MAX) ? CUR_MAX : cur_sum[CUR_W-1:0];
                    if (usage_now > usage_peak)
                        usage_peak = usage_now;
                    tot_sum     = {1'b0, usage_total} + ev.size;
                    usage_total = (tot_sum > TOT_MAX) ? TOT_MAX : tot_sum[TOT_W-1:0];
                end
            end
        end else begin
            if (ev.address == '0)
                res.status = ST_NULL_FREE;
            else begin
                // newest matching entry; lowest index wins a tie
                for (int i = 0; i < DEPTH; i++)
                    if (live_valid[i] && live_addr[i] == ev.address)
                        if (hit < 0 || live_age[i] > live_age[hit])
                            hit = i;
                if (hit < 0)
                    res.status = ST_UNKNOWN_FREE;
                else begin
                    live_valid[hit] = 1'b0;
                    res.freed_size  = live_size[hit];
                    if (usage_now >= live_size[hit])
                        usage_now = usage_now - live_size[hit];
                    else
                        usage_now = '0;
                end
            end
        end
        res.current_bytes = usage_now;
        res.peak_bytes    = usage_peak;
        res.total_bytes   = usage_total;
        return res;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (live_valid[i])
                n++;
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] any_nonzero_addr();
        logic [ADDR_W-1:0] a;
        a = $urandom;
        if (a == '0)
            a = 32'h1;
        return a;
    endfunction

    // Address of some live entry, or a fresh one if the table is empty
    function automatic logic [ADDR_W-1:0] live_addr_pick();
        int idx [$];
        for (int i = 0; i < DEPTH; i++)
            if (live_valid[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return any_nonzero_addr();
        return live_addr[idx[$urandom_range(idx.size() - 1)]];
    endfunction

    // Mostly in-range sizes, now and then the full 17-bit span
    function automatic logic [SIZE_W-1:0] size_pick();
        if ($urandom_range(7) == 0)
            return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
        return SIZE_W'($urandom_range(0, 99999));
    endfunction

    function automatic req_t make_item(logic f, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
        req_t it;
        it.func    = f;
        it.address = a;
        it.size    = s;
        return it;
    endfunction

    function automatic void add_row(logic f, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                                    bit typed, status_t st, logic [SIZE_W-1:0] fr,
                                    logic [CUR_W-1:0] cur, logic [CUR_W-1:0] pk,
                                    logic [TOT_W-1:0] tot);
        script_row_t row;
        row.item               = make_item(f, a, s);
        row.typed              = typed;
        row.want.status        = st;
        row.want.freed_size    = fr;
        row.want.current_bytes = cur;
        row.want.peak_bytes    = pk;
        row.want.total_bytes   = tot;
        script.push_back(row);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[tb] mismatch at response %0d: %s", rsp_seen, msg);
        error_count++;
    endtask

    // Present one item, hold it until taken, then queue its expected response
    task automatic push_item(req_t item, bit typed, rsp_t typed_rsp);
        rsp_t predicted;
        if ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = track_event(item);
        status_seen[predicted.status]++;
        items_sent++;
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic push_random(req_t item);
        push_item(item, 1'b0, '0);
        random_sent++;
    endtask

    // Hold off the sender until every outstanding response is back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idle_mix(int mix);
        idle_mix = mix;
        case (mix)
            0: begin sender_idle_pct = 8;  receiver_idle_pct = 77; end
            1: begin sender_idle_pct = 77; receiver_idle_pct = 8;  end
            default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
        endcase
    endtask

    // Fill the table, overflow it, then release part of it
    task automatic fill_episode();
        int extra;
        int releases;
        extra    = $urandom_range(1, 3);
        releases = $urandom_range(8, 48);
        while (live_count() < DEPTH)
            push_random(make_item(FUNC_ALLOC,
                ($urandom_range(9) < 3) ? addr_pool[$urandom_range(POOL_N - 1)]
                                        : any_nonzero_addr(), size_pick()));
        repeat (extra)
            push_random(make_item(FUNC_ALLOC,
                ($urandom_range(3) == 0) ? '0 : any_nonzero_addr(), size_pick()));
        repeat (releases)
            push_random(make_item(FUNC_FREE, live_addr_pick(), size_pick()));
    endtask

    // Free everything that is live
    task automatic drain_episode();
        while (live_count() > 0)
            push_random(make_item(FUNC_FREE, live_addr_pick(), size_pick()));
    endtask

    // Allocate and free a small address pool so duplicates pile up
    task automatic churn_episode();
        int pick;
        for (int k = 0; k < POOL_N; k++)
            addr_pool[k] = any_nonzero_addr();
        repeat (16) begin
            pick = $urandom_range(99);
            if (pick < 55)
                push_random(make_item(FUNC_ALLOC, addr_pool[$urandom_range(POOL_N - 1)],
                                      size_pick()));
            else if (pick < 95)
                push_random(make_item(FUNC_FREE,
                    ($urandom_range(9) < 7) ? live_addr_pick()
                                            : addr_pool[$urandom_range(POOL_N - 1)],
                    size_pick()));
            else
                push_random(make_item(1'($urandom_range(1)), '0, size_pick()));
        end
    endtask

    // Unshaped items across the full field ranges
    task automatic noise_episode();
        repeat (8)
            push_random(make_item(1'($urandom_range(1)),
                ($urandom_range(4) == 0) ? '0 : ADDR_W'($urandom),
                SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1))));
    endtask

    // Check each accepted response and set the next stall
    always @(posedge clk) begin
        rsp_t        want;
        logic [63:0] got_f  [5];
        logic [63:0] want_f [5];
        string       names  [5];
        names = '{"status", "freed_size", "current_bytes", "peak_bytes", "total_bytes"};
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("response with nothing outstanding (status %0d)",
                                          rsp.status));
            else begin
                want      = pending_rsp.pop_front();
                got_f[0]  = 64'(rsp.status);
                got_f[1]  = 64'(rsp.freed_size);
                got_f[2]  = 64'(rsp.current_bytes);
                got_f[3]  = 64'(rsp.peak_bytes);
                got_f[4]  = 64'(rsp.total_bytes);
                want_f[0] = 64'(want.status);
                want_f[1] = 64'(want.freed_size);
                want_f[2] = 64'(want.current_bytes);
                want_f[3] = 64'(want.peak_bytes);
                want_f[4] = 64'(want.total_bytes);
                for (int f = 0; f < 5; f++)
                    if (got_f[f] !== want_f[f])
                        report_mismatch($sformatf("%s got %0d, expected %0d",
                                                  names[f], got_f[f], want_f[f]));
            end
            rsp_seen++;
        end
        rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[tb] no progress for %0d cycles", QUIET_LIMIT);
            $display("[allocation_tracker_top] ERROR");
            $finish;
        end
    end

    initial begin
        int pick;
        for (int i = 0; i < DEPTH; i++) begin
            live_valid[i] = 1'b0;
            live_addr[i]  = '0;
            live_size[i]  = '0;
            live_age[i]   = '0;
        end
        for (int s = 0; s < 5; s++)
            status_seen[s] = 0;
        for (int k = 0; k < POOL_N; k++)
            addr_pool[k] = any_nonzero_addr();
        event_age   = '0;
        usage_now   = '0;
        usage_peak  = '0;
        usage_total = '0;

        // Directed items; typed rows carry results that follow at a glance
        add_row(FUNC_ALLOC, 32'h0000_0000, 17'd5,       1, ST_NULL_ALLOC,   0, 0, 0, 0);
        add_row(FUNC_FREE,  32'h0000_0000, 17'd0,       1, ST_NULL_FREE,    0, 0, 0, 0);
        add_row(FUNC_FREE,  32'h0000_1234, 17'd0,       1, ST_UNKNOWN_FREE, 0, 0, 0, 0);
        add_row(FUNC_ALLOC, 32'hFFFF_FFFF, 17'd99999,   1, ST_OK, 0, 99999, 99999, 99999);
        add_row(FUNC_ALLOC, 32'h0000_0001, 17'd0,       1, ST_OK, 0, 99999, 99999, 99999);
        add_row(FUNC_ALLOC, 32'hFFFF_FFFF, 17'h1FFFF,   1, ST_OK, 0,
                231070, 231070, 231070);
        add_row(FUNC_FREE,  32'hFFFF_FFFF, 17'd0,       1, ST_OK, 17'h1FFFF,
                99999, 231070, 231070);
        add_row(FUNC_FREE,  32'hFFFF_FFFF, 17'd0,       1, ST_OK, 99999, 0, 231070, 231070);
        add_row(FUNC_FREE,  32'hFFFF_FFFF, 17'd0,       1, ST_UNKNOWN_FREE, 0,
                0, 231070, 231070);
        add_row(FUNC_FREE,  32'h0000_0001, 17'd0,       1, ST_OK, 0, 0, 231070, 231070);
        add_row(FUNC_ALLOC, 32'hAAAA_AAAA, 17'h0AAAA,   0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_ALLOC, 32'h5555_5555, 17'h15555,   0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_ALLOC, 32'hAAAA_AAAA, 17'd100000,  0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_FREE,  32'hAAAA_AAAA, 17'h1FFFF,   0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_ALLOC, 32'h0000_0000, 17'h1FFFF,   0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_FREE,  32'h5555_5555, 17'd0,       0, ST_OK, 0, 0, 0, 0);
        add_row(FUNC_FREE,  32'hAAAA_AAAA, 17'd0,       0, ST_OK, 0, 0, 0, 0);

        set_idle_mix(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            push_item(script[i].item, script[i].typed, script[i].want);
        wait_drained();

        // Random episodes; switch idle mix by thirds, pausing at each switch
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent * 3 / RANDOM_ITEMS != idle_mix) begin
                wait_drained();
                set_idle_mix(random_sent * 3 / RANDOM_ITEMS);
            end
            pick = $urandom_range(99);
            if (pick < 12)
                fill_episode();
            else if (pick < 20)
                drain_episode();
            else if (pick < 75)
                churn_episode();
            else
                noise_episode();
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("[tb] %0d items, %0d responses: %0d ok, %0d null alloc, %0d null free,",
                 items_sent, rsp_seen, status_seen[ST_OK], status_seen[ST_NULL_ALLOC],
                 status_seen[ST_NULL_FREE]);
        $display("[tb] %0d unknown free, %0d table full; peak %0d bytes, %0d mismatches",
                 status_seen[ST_UNKNOWN_FREE], status_seen[ST_FULL], usage_peak, error_count);
        if (error_count == 0)
            $display("[allocation_tracker_top] OK");
        else
            $display("[allocation_tracker_top] ERROR");
        $finish;
    end

endmodule
